// ===== src/rsps_pkg.sv =====
// Shared constants for the ray-sphere pixel shader.
// No dependencies; imported by the pipeline modules.
`default_nettype none
package rsps_pkg;

  // Configuration register map
  localparam int REG_IMAGE_SIZE = 0;
  localparam int SIZE_W = 11;
  localparam logic [SIZE_W-1:0] IMAGE_SIZE_RESET = 11'd500;

  // Fixed-point formats
  localparam int PIX_W = 10;
  localparam int COORD_W = 17;    // signed Q2.14 with headroom
  localparam int CHAN_W = 16;

  // Square root unit: 34-bit operand, 17-bit root
  localparam int SQ_IN_W = 34;
  localparam int SQ_OUT_W = 17;

endpackage
`default_nettype wire

// ===== src/rsps_div_pipe.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
// Stand-alone; a tag rides along each stage with the operands.
`default_nettype none
module rsps_div_pipe #(
  parameter int DVD_W = 27,
  parameter int DVS_W = 12,
  parameter int QUO_W = 15,
  parameter int TAG_W = 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             ce,
  input  wire logic [DVD_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  input  wire logic [TAG_W-1:0] tag_in,
  output logic      [QUO_W-1:0] quotient,
  output logic      [TAG_W-1:0] tag_out
);

  localparam int W = DVS_W + QUO_W;

  logic [W-1:0]     rem_i [QUO_W];
  logic [DVS_W-1:0] dvs_i [QUO_W];
  logic [QUO_W-1:0] quo_i [QUO_W];
  logic [TAG_W-1:0] tag_i [QUO_W];

  logic [W-1:0]     rem_q [QUO_W-1];
  logic [DVS_W-1:0] dvs_q [QUO_W-1];
  logic [QUO_W-1:0] quo_q [QUO_W];
  logic [TAG_W-1:0] tag_q [QUO_W];

  assign rem_i[0] = W'(dividend);
  assign dvs_i[0] = divisor;
  assign quo_i[0] = '0;
  assign tag_i[0] = tag_in;

  genvar k;
  for (k = 0; k < QUO_W; k++) begin : g_stage
    localparam int SH = QUO_W - 1 - k;
    logic [W-1:0]     dsh;
    logic             ge;
    logic [W-1:0]     rem_n;
    logic [QUO_W-1:0] quo_n;

    if (k > 0) begin : g_link
      assign rem_i[k] = rem_q[k-1];
      assign dvs_i[k] = dvs_q[k-1];
      assign quo_i[k] = quo_q[k-1];
      assign tag_i[k] = tag_q[k-1];
    end

    always_comb begin
      dsh = W'(dvs_i[k]) << SH;
      ge = rem_i[k] >= dsh;
      rem_n = ge ? rem_i[k] - dsh : rem_i[k];
      quo_n = quo_i[k];
      quo_n[SH] = ge;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        tag_q[k] <= '0;
      end else if (ce) begin
        tag_q[k] <= tag_i[k];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        quo_q[k] <= quo_n;
      end
    end

    if (k < QUO_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (ce) begin
          rem_q[k] <= rem_n;
          dvs_q[k] <= dvs_i[k];
        end
      end
    end
  end

  assign quotient = quo_q[QUO_W-1];
  assign tag_out = tag_q[QUO_W-1];

endmodule
`default_nettype wire

// ===== src/rsps_sqrt_pipe.sv =====
// Pipelined integer square root, one root bit per register stage.
// Depends on rsps_pkg for operand and root widths.
`default_nettype none
module rsps_sqrt_pipe #(
  parameter int TAG_W = 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          ce,
  input  wire logic [rsps_pkg::SQ_IN_W-1:0]  operand,
  input  wire logic [TAG_W-1:0]              tag_in,
  output logic      [rsps_pkg::SQ_OUT_W-1:0] root,
  output logic      [TAG_W-1:0]              tag_out
);

  import rsps_pkg::*;

  localparam int N = SQ_OUT_W;
  localparam int RW = SQ_OUT_W + 3;

  logic [RW-1:0]      rem_i [N];
  logic [SQ_IN_W-1:0] op_i [N];
  logic [N-1:0]       root_i [N];
  logic [TAG_W-1:0]   tag_i [N];

  logic [RW-1:0]      rem_q [N-1];
  logic [SQ_IN_W-1:0] op_q [N-1];
  logic [N-1:0]       root_q [N];
  logic [TAG_W-1:0]   tag_q [N];

  assign rem_i[0] = '0;
  assign op_i[0] = operand;
  assign root_i[0] = '0;
  assign tag_i[0] = tag_in;

  genvar k;
  for (k = 0; k < N; k++) begin : g_stage
    logic [RW-1:0] rem_sh;
    logic [RW-1:0] trial;
    logic          ge;

    if (k > 0) begin : g_link
      assign rem_i[k] = rem_q[k-1];
      assign op_i[k] = op_q[k-1];
      assign root_i[k] = root_q[k-1];
      assign tag_i[k] = tag_q[k-1];
    end

    // bring down the next two operand bits, try root*4+1
    always_comb begin
      rem_sh = {rem_i[k][RW-3:0], op_i[k][SQ_IN_W-1 -: 2]};
      trial = RW'({root_i[k], 2'b01});
      ge = rem_sh >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        tag_q[k] <= '0;
      end else if (ce) begin
        tag_q[k] <= tag_i[k];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        root_q[k] <= {root_i[k][N-2:0], ge};
      end
    end

    if (k < N - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (ce) begin
          rem_q[k] <= ge ? rem_sh - trial : rem_sh;
          op_q[k] <= op_i[k] << 2;
        end
      end
    end
  end

  assign root = root_q[N-1];
  assign tag_out = tag_q[N-1];

endmodule
`default_nettype wire

// ===== src/rsps_out_buf.sv =====
// Two-entry output buffer that decouples the pipeline from the receiver.
// Stand-alone; space is a registered-state decision, not a function of ready.
`default_nettype none
module rsps_out_buf #(
  parameter int W = 49
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  output logic              space,
  output logic              m_valid,
  output logic [W-1:0]      m_data,
  input  wire logic         m_ready
);

  logic [W-1:0] mem [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic [1:0]   count_next;
  logic         pop;

  assign pop = m_valid & m_ready;
  assign space = count != 2'd2;
  assign m_valid = count != 2'd0;
  assign m_data = mem[rd_ptr];

  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      count <= count_next;
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

// ===== src/ray_sphere_pixel_shader.sv =====
// Ray-sphere pixel shader: pixel coordinate in, shaded color out.
// Input beat on s_t*: tdata = {pixel_y, pixel_x}; output beat on m_t*:
// tdata = {blue, green, red}, tuser = sphere_hit. image_size sits on the
// APB port at byte address 0 and may only change while the block is empty.
// Each pixel is cast as a ray from the origin through its center on a 2x2
// viewport at z = -1 and tested against a sphere of radius 0.5 at (0,0,-1).
// An accepted input beat passes, in order, a 15-stage divider for the pixel
// centers, two stages for the ray length, a 17-stage square root, one setup
// stage, a 30-stage divider for the hit distance or sky blend, and four
// stages of shading and channel scaling. Throughput is one pixel per cycle
// while the output buffer has room. The whole pipeline advances on a single
// enable that is high while the two-entry output buffer has room; when the
// receiver stalls, the buffer fills, the enable drops and s_tready falls,
// freezing every stage with its valid bit so nothing is lost or repeated.
// Reset is synchronous: it empties the pipeline and buffer and sets
// image_size to 500.
// Depends on rsps_pkg, rsps_div_pipe, rsps_sqrt_pipe and rsps_out_buf.
`default_nettype none
module ray_sphere_pixel_shader #(
  parameter int MAX_IMAGE_SIZE = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // APB configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // pixel stream in
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // [9:0] pixel_x, [19:10] pixel_y, rest zero
  // color stream out
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [47:0] m_tdata,   // [15:0] red, [31:16] green, [47:32] blue
  output logic             m_tuser    // [0] sphere_hit
);

  import rsps_pkg::*;

  typedef struct packed {
    logic                      valid;
    logic                      hit;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [29:0]               a;
  } sq_tag_t;

  typedef struct packed {
    logic                      valid;
    logic                      hit;
    logic                      neg;
  } dv_tag_t;

  function automatic logic [CHAN_W-1:0] to_channel(input logic signed [32:0] v);
    logic [48:0] w;
    logic [18:0] u;
    w = ({17'b0, v[31:0]} << 16) - {17'b0, v[31:0]} + 49'(1 << 29);
    u = w[48:30];
    if (v <= 0) begin
      return '0;
    end else if (u > 19'd65535) begin
      return 16'hFFFF;
    end else begin
      return u[CHAN_W-1:0];
    end
  endfunction

  // ---------------- configuration ----------------
  logic [SIZE_W-1:0] image_size;
  logic              reg_sel;

  assign pready = 1'b1;
  assign reg_sel = paddr[2] == 1'(REG_IMAGE_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_size <= IMAGE_SIZE_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      image_size <= pwdata[SIZE_W-1:0];
    end
  end

  assign prdata = reg_sel ? {{(32-SIZE_W){1'b0}}, image_size} : 32'd0;

  // ---------------- enable and input ----------------
  logic ce;
  logic in_valid;

  assign s_tready = ce;
  assign in_valid = s_tvalid;

  logic [SIZE_W-1:0] n_eff;
  logic [SIZE_W-1:0] n_m1;
  logic [SIZE_W-1:0] idx_x;
  logic [SIZE_W-1:0] idx_y;
  logic [26:0]       dvd_x;
  logic [26:0]       dvd_y;
  logic [11:0]       dvs_n;

  always_comb begin
    if (image_size == '0) begin
      n_eff = SIZE_W'(1);
    end else if (int'(image_size) > MAX_IMAGE_SIZE) begin
      n_eff = SIZE_W'(MAX_IMAGE_SIZE);
    end else begin
      n_eff = image_size;
    end
    n_m1 = n_eff - SIZE_W'(1);
    idx_x = SIZE_W'(s_tdata[PIX_W-1:0]);
    idx_y = SIZE_W'(s_tdata[2*PIX_W-1:PIX_W]);
    if (idx_x > n_m1) begin
      idx_x = n_m1;
    end
    if (idx_y > n_m1) begin
      idx_y = n_m1;
    end
    // round((2i+1) * 2^15 / 2n) as floor((2i+1)*2^15 + n) / 2n
    dvd_x = {idx_x, 1'b1, 15'b0} + 27'(n_eff);
    dvd_y = {idx_y, 1'b1, 15'b0} + 27'(n_eff);
    dvs_n = {n_eff, 1'b0};
  end

  // ---------------- pixel center dividers ----------------
  logic [14:0] qx;
  logic [14:0] qy;
  logic        tx;
  logic        ty;

  rsps_div_pipe #(.DVD_W(27), .DVS_W(12), .QUO_W(15), .TAG_W(1)) u_div_x (
    .clk(clk), .rst(rst), .ce(ce),
    .dividend(dvd_x), .divisor(dvs_n), .tag_in(in_valid),
    .quotient(qx), .tag_out(tx)
  );

  rsps_div_pipe #(.DVD_W(27), .DVS_W(12), .QUO_W(15), .TAG_W(1)) u_div_y (
    .clk(clk), .rst(rst), .ce(ce),
    .dividend(dvd_y), .divisor(dvs_n), .tag_in(in_valid),
    .quotient(qy), .tag_out(ty)
  );

  // ---------------- ray direction and squares ----------------
  logic                      a1_valid;
  logic signed [COORD_W-1:0] a1_x;
  logic signed [COORD_W-1:0] a1_y;
  logic [28:0]               a1_xx;
  logic [28:0]               a1_yy;
  logic signed [COORD_W-1:0] dir_x;
  logic signed [COORD_W-1:0] dir_y;
  logic signed [33:0]        sq_x;
  logic signed [33:0]        sq_y;

  always_comb begin
    dir_x = $signed({2'b0, qx}) - 17'sd16384;
    dir_y = 17'sd16384 - $signed({2'b0, qy});
    sq_x = dir_x * dir_x;
    sq_y = dir_y * dir_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a1_valid <= 1'b0;
    end else if (ce) begin
      a1_valid <= tx & ty;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      a1_x <= dir_x;
      a1_y <= dir_y;
      a1_xx <= sq_x[28:0];
      a1_yy <= sq_y[28:0];
    end
  end

  // ---------------- length, hit test, root operand ----------------
  logic [29:0]        len2;
  logic [31:0]        len2_x3;
  logic               hit_w;
  logic [31:0]        disc;
  logic [SQ_IN_W-1:0] sq_op;
  sq_tag_t            a2_tag;
  logic [SQ_IN_W-1:0] a2_op;

  always_comb begin
    len2 = 30'(a1_xx) + 30'(a1_yy) + 30'(1 << 28);
    len2_x3 = {2'b0, len2} + {1'b0, len2, 1'b0};
    hit_w = len2_x3 <= 32'(1 << 30);
    disc = 32'(1 << 30) - len2_x3;
    sq_op = hit_w ? {disc[29:0], 4'b0} : {len2, 4'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a2_tag.valid <= 1'b0;
    end else if (ce) begin
      a2_tag.valid <= a1_valid;
    end
    if (ce) begin
      a2_tag.hit <= hit_w;
      a2_tag.x <= a1_x;
      a2_tag.y <= a1_y;
      a2_tag.a <= len2;
      a2_op <= sq_op;
    end
  end

  // ---------------- square root ----------------
  logic [SQ_OUT_W-1:0] sq_root;
  sq_tag_t             sq_tag;

  rsps_sqrt_pipe #(.TAG_W($bits(sq_tag_t))) u_sqrt (
    .clk(clk), .rst(rst), .ce(ce),
    .operand(a2_op), .tag_in(a2_tag),
    .root(sq_root), .tag_out(sq_tag)
  );

  // ---------------- second divider setup ----------------
  logic [45:0]               dvd_b;
  logic [30:0]               dvs_b;
  logic [17:0]               num_b;
  logic [14:0]               ymag;
  logic [45:0]               b_dvd;
  logic [30:0]               b_dvs;
  dv_tag_t                   b_tag;
  logic signed [COORD_W-1:0] b_x;
  logic signed [COORD_W-1:0] b_y;

  always_comb begin
    num_b = 18'(1 << 17) - 18'(sq_root);
    ymag = sq_tag.y[COORD_W-1] ? 15'(-sq_tag.y) : 15'(sq_tag.y);
    if (sq_tag.hit) begin
      dvd_b = {num_b[17:0], 28'b0} + 46'(sq_tag.a);
      dvs_b = {sq_tag.a, 1'b0};
    end else begin
      dvd_b = {ymag, 31'b0};
      dvs_b = 31'(sq_root);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_tag.valid <= 1'b0;
    end else if (ce) begin
      b_tag.valid <= sq_tag.valid;
    end
    if (ce) begin
      b_tag.hit <= sq_tag.hit;
      b_tag.neg <= sq_tag.y[COORD_W-1];
      b_x <= sq_tag.x;
      b_y <= sq_tag.y;
      b_dvd <= dvd_b;
      b_dvs <= dvs_b;
    end
  end

  // ---------------- distance / blend divider ----------------
  localparam int XY_W = 2 * COORD_W;
  logic [29:0]     d2_quo;
  dv_tag_t         d2_tag;
  logic [XY_W-1:0] d2_xy;

  rsps_div_pipe #(
    .DVD_W(46), .DVS_W(31), .QUO_W(30), .TAG_W($bits(dv_tag_t) + XY_W)
  ) u_div_t (
    .clk(clk), .rst(rst), .ce(ce),
    .dividend(b_dvd), .divisor(b_dvs), .tag_in({b_tag, b_x, b_y}),
    .quotient(d2_quo), .tag_out({d2_tag, d2_xy})
  );

  // ---------------- shade stage 1: products, sky blend ----------------
  logic signed [COORD_W-1:0] d2_x;
  logic signed [COORD_W-1:0] d2_y;
  logic signed [31:0]        blend;
  logic [30:0]               a30;
  logic                      s1_valid;
  logic                      s1_hit;
  logic [16:0]               s1_t;
  logic signed [34:0]        s1_px;
  logic signed [34:0]        s1_py;
  logic [30:0]               s1_redm;
  logic [31:0]               s1_g3;

  assign d2_x = d2_xy[XY_W-1:COORD_W];
  assign d2_y = d2_xy[COORD_W-1:0];

  always_comb begin
    blend = d2_tag.neg ? 32'sd536870912 - $signed({2'b0, d2_quo})
                       : 32'sd536870912 + $signed({2'b0, d2_quo});
    if (blend < 0) begin
      a30 = '0;
    end else if (blend > 32'sd1073741824) begin
      a30 = 31'(1 << 30);
    end else begin
      a30 = blend[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (ce) begin
      s1_valid <= d2_tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s1_hit <= d2_tag.hit;
      s1_t <= d2_quo[16:0];
      s1_px <= $signed({1'b0, d2_quo[16:0]}) * d2_x;
      s1_py <= $signed({1'b0, d2_quo[16:0]}) * d2_y;
      s1_redm <= 31'(1 << 30) - (a30 >> 1);
      s1_g3 <= {a30, 1'b0} + 32'(a30) + 32'd5;
    end
  end

  // ---------------- shade stage 2: hit colors, divide by ten ----------------
  logic               s2_valid;
  logic               s2_hit;
  logic signed [32:0] s2_vr;
  logic signed [32:0] s2_vg;
  logic signed [32:0] s2_vb;
  logic [63:0]        s2_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (ce) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s2_hit <= s1_hit;
      s2_vr <= s1_hit ? $signed(s1_px[32:0]) + 33'sd536870912 : $signed({2'b0, s1_redm});
      s2_vg <= $signed(s1_py[32:0]) + 33'sd536870912;
      s2_vb <= 33'sd1610612736 - $signed({2'b0, s1_t, 14'b0});
      // floor(v / 10) = (v * 0xCCCCCCCD) >> 35 for any 32-bit v
      s2_prod <= 64'(s1_g3) * 64'hCCCC_CCCD;
    end
  end

  // ---------------- shade stage 3: select colors ----------------
  logic               s3_valid;
  logic               s3_hit;
  logic signed [32:0] s3_vr;
  logic signed [32:0] s3_vg;
  logic signed [32:0] s3_vb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (ce) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s3_hit <= s2_hit;
      s3_vr <= s2_vr;
      s3_vg <= s2_hit ? s2_vg : 33'sd1073741824 - $signed({4'b0, s2_prod[63:35]});
      s3_vb <= s2_hit ? s2_vb : 33'sd1073741824;
    end
  end

  // ---------------- shade stage 4: scale to channels ----------------
  logic              s4_valid;
  logic              s4_hit;
  logic [CHAN_W-1:0] s4_r;
  logic [CHAN_W-1:0] s4_g;
  logic [CHAN_W-1:0] s4_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (ce) begin
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s4_hit <= s3_hit;
      s4_r <= to_channel(s3_vr);
      s4_g <= to_channel(s3_vg);
      s4_b <= to_channel(s3_vb);
    end
  end

  // ---------------- output buffer ----------------
  logic [48:0] ob_data;

  rsps_out_buf #(.W(49)) u_out_buf (
    .clk(clk), .rst(rst),
    .push(ce & s4_valid), .push_data({s4_hit, s4_b, s4_g, s4_r}),
    .space(ce),
    .m_valid(m_tvalid), .m_data(ob_data), .m_ready(m_tready)
  );

  assign m_tdata = ob_data[47:0];
  assign m_tuser = ob_data[48];

endmodule
`default_nettype wire

// ===== test/tb_ray_sphere_pixel_shader.sv =====
// Self-checking testbench for ray_sphere_pixel_shader: pixel beats in, color beats out.
// Uses rsps_pkg for the register map. A built-in shading model predicts every beat.
`timescale 1ns / 1ps
module tb_ray_sphere_pixel_shader;
  import rsps_pkg::*;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic        hit;
  } color_t;

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid, s_tready;
  logic [23:0] s_tdata;
  logic        m_tvalid, m_tready;
  logic [47:0] m_tdata;
  logic        m_tuser;

  ray_sphere_pixel_shader u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  logic [23:0] pixel_q[$];
  color_t      color_q[$];
  logic [10:0] size_cfg;
  int          send_idle_pct, recv_stall_pct;
  int          errors, pixels_sent, colors_seen, hits_seen, idle_cycles;
  bit          in_fire;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] scale_channel(longint v30);
    longint u;
    if (v30 <= 0) return 16'd0;
    u = (v30 * 65535 + (64'sd1 << 29)) >>> 30;
    return (u > 65535) ? 16'hFFFF : u[15:0];
  endfunction

  function automatic longint center_offset(longint idx, longint n);
    return ((2 * idx + 1) * 32768 + n) / (2 * n) - 16384;
  endfunction

  function automatic color_t shade_pixel(logic [9:0] px, logic [9:0] py, logic [10:0] sz);
    longint n, xi, yi, x, y, a2, h, s, t, len, a30;
    color_t c;
    n  = sz;
    xi = px;
    yi = py;
    if (n == 0) n = 1;
    if (n > 1024) n = 1024;
    if (xi > n - 1) xi = n - 1;
    if (yi > n - 1) yi = n - 1;
    x  = center_offset(xi, n);
    y  = -center_offset(yi, n);
    a2 = x * x + y * y + (64'sd1 << 28);
    if (3 * a2 <= (64'sd1 << 30)) begin
      h = (64'sd1 << 30) - 3 * a2;
      s = int_sqrt(h << 4);
      t = ((((64'sd1 << 17) - s) << 28) + a2) / (2 * a2);
      c.red   = scale_channel(t * x + (64'sd1 << 29));
      c.green = scale_channel(t * y + (64'sd1 << 29));
      c.blue  = scale_channel(3 * (64'sd1 << 29) - t * 16384);
      c.hit   = 1'b1;
    end else begin
      len = int_sqrt(a2 << 4);
      a30 = (64'sd1 << 29) + (y * (64'sd1 << 31)) / len;
      if (a30 < 0) a30 = 0;
      if (a30 > (64'sd1 << 30)) a30 = 64'sd1 << 30;
      c.red   = scale_channel((64'sd1 << 30) - a30 / 2);
      c.green = scale_channel((64'sd1 << 30) - (3 * a30 + 5) / 10);
      c.blue  = 16'hFFFF;
      c.hit   = 1'b0;
    end
    return c;
  endfunction

  // Driver: hold a beat until it is taken, then maybe idle.
  always @(negedge clk) begin
    if (!rst) begin
      if (!s_tvalid || in_fire) begin
        if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_tvalid <= 1'b1;
          s_tdata  <= pixel_q.pop_front();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor and scoreboard.
  always @(posedge clk) begin
    color_t exp_c, got;
    in_fire <= s_tvalid && s_tready && !rst;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        color_q.push_back(shade_pixel(s_tdata[9:0], s_tdata[19:10], size_cfg));
        pixels_sent++;
      end
      if (m_tvalid && m_tready) begin
        got = {m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tuser};
        colors_seen++;
        if (m_tuser) hits_seen++;
        if (color_q.size() == 0) begin
          $display("%0t: unexpected color beat %h", $time, got);
          errors++;
        end else begin
          exp_c = color_q.pop_front();
          if (got.red !== exp_c.red) begin
            $display("%0t: red exp %0d got %0d", $time, exp_c.red, got.red);
            errors++;
          end
          if (got.green !== exp_c.green) begin
            $display("%0t: green exp %0d got %0d", $time, exp_c.green, got.green);
            errors++;
          end
          if (got.blue !== exp_c.blue) begin
            $display("%0t: blue exp %0d got %0d", $time, exp_c.blue, got.blue);
            errors++;
          end
          if (got.hit !== exp_c.hit) begin
            $display("%0t: sphere_hit exp %0d got %0d", $time, exp_c.hit, got.hit);
            errors++;
          end
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= 5000) begin
        $display("%0t: watchdog expired", $time);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic write_size(logic [10:0] val);
    @(negedge clk);
    psel = 1; pwrite = 1; penable = 0;
    paddr = 3'(REG_IMAGE_SIZE * 4);
    pwdata = 32'(val);
    @(negedge clk);
    penable = 1;
    @(posedge clk);
    size_cfg = val;
    @(negedge clk);
    pwrite = 0; penable = 0;
    @(negedge clk);
    penable = 1;
    @(posedge clk);
    if (prdata[10:0] !== val) begin
      $display("%0t: image_size readback exp %0d got %0d", $time, val, prdata[10:0]);
      errors++;
    end
    @(negedge clk);
    psel = 0; penable = 0;
  endtask

  task automatic drain;
    wait (pixel_q.size() == 0 && !s_tvalid && color_q.size() == 0);
    repeat (90) @(posedge clk);
  endtask

  task automatic add_pixel(int px, int py);
    pixel_q.push_back({4'b0, 10'(py), 10'(px)});
  endtask

  initial begin
    int sizes[10] = '{1, 0, 1024, 2047, 1025, 2, 3, 7, 64, 333};
    int lim;
    rst = 1;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    s_tvalid = 0; s_tdata = 0; m_tready = 0;
    size_cfg = IMAGE_SIZE_RESET;
    send_idle_pct = 0; recv_stall_pct = 0;
    errors = 0; pixels_sent = 0; colors_seen = 0; hits_seen = 0; idle_cycles = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Corners, center, pixels past the edge at the reset size.
    add_pixel(0, 0);       add_pixel(499, 499);   add_pixel(1023, 1023);
    add_pixel(0, 1023);    add_pixel(1023, 0);    add_pixel(249, 249);
    add_pixel(250, 250);   add_pixel(249, 0);     add_pixel(0, 249);
    add_pixel(125, 250);   add_pixel(375, 250);   add_pixel(250, 125);
    add_pixel(250, 375);   add_pixel(682, 341);   add_pixel(341, 682);
    add_pixel(500, 500);   add_pixel(511, 512);
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 72; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 72; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      write_size(ph < 10 ? 11'(sizes[ph]) : 11'($urandom_range(2047)));
      lim = (size_cfg == 0) ? 1 : size_cfg;
      for (int i = 0; i < 103; i++) begin
        if ($urandom_range(3) == 0) add_pixel($urandom_range(1023), $urandom_range(1023));
        else add_pixel($urandom_range(lim - 1 > 1023 ? 1023 : lim - 1),
                       $urandom_range(lim - 1 > 1023 ? 1023 : lim - 1));
      end
      drain();
    end

    $display("Covered %0d pixels over 13 image sizes (%0d sphere hits, %0d colors checked).",
             pixels_sent, hits_seen, colors_seen);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule

// ===== files.f =====
src/rsps_pkg.sv
src/rsps_div_pipe.sv
src/rsps_sqrt_pipe.sv
src/rsps_out_buf.sv
src/ray_sphere_pixel_shader.sv
test/tb_ray_sphere_pixel_shader.sv
